// ----- hw/rtl/blbr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_pkg
// shared types and constants for the line brush rasteriser
// ----------------------------------------------------------------------------
package blbr_pkg;

    localparam int COORD_W    = 10;
    localparam int COLOUR_W   = 8;
    localparam int SIDE_W     = 4;
    localparam int DECISION_W = 12;
    localparam int SIDE_CMP_W = 5;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ADVANCE = 1'b1;

    typedef logic [COORD_W-1:0]  coord_t;
    typedef logic [COLOUR_W-1:0] colour_t;

    // line set-up worked out from a load request
    typedef struct packed {
        logic                         steep;
        coord_t                       major_pos;
        coord_t                       minor_pos;
        coord_t                       major_end;
        coord_t                       delta_major;
        coord_t                       delta_minor;
        logic signed [DECISION_W-1:0] decision;
        logic                         minor_down;
        logic [SIDE_W-1:0]            brush_side;
        colour_t                      red;
        colour_t                      green;
        colour_t                      blue;
    } line_setup_t;

    // pixel write produced by an advance request
    typedef struct packed {
        logic    valid;
        coord_t  x;
        coord_t  y;
        colour_t red;
        colour_t green;
        colour_t blue;
        logic    last;
    } pixel_t;

endpackage

// ----- hw/rtl/blbr_setup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_setup
// orders the endpoints along the major axis and forms the decision term
// ----------------------------------------------------------------------------
module blbr_setup
    import blbr_pkg::*;
#(
    parameter int BRUSH_MAX = 8
)
(
    input  coord_t            x_start,
    input  coord_t            y_start,
    input  coord_t            x_end,
    input  coord_t            y_end,
    input  colour_t           red,
    input  colour_t           green,
    input  colour_t           blue,
    input  logic [SIDE_W-1:0] brush,
    output line_setup_t       setup
);

    coord_t            adx;
    coord_t            ady;
    logic              steep;
    coord_t            a0;
    coord_t            b0;
    coord_t            a1;
    coord_t            b1;
    coord_t            ma0;
    coord_t            mb0;
    coord_t            ma1;
    coord_t            mb1;
    coord_t            dminor;
    logic [SIDE_W-1:0] side;

    always_comb
    begin
        adx   = (x_start > x_end) ? (x_start - x_end) : (x_end - x_start);
        ady   = (y_start > y_end) ? (y_start - y_end) : (y_end - y_start);
        steep = ady > adx;

        if (steep)
        begin
            a0 = y_start;
            b0 = x_start;
            a1 = y_end;
            b1 = x_end;
        end
        else
        begin
            a0 = x_start;
            b0 = y_start;
            a1 = x_end;
            b1 = y_end;
        end

        // walk always runs towards the larger major coordinate
        if (a0 > a1)
        begin
            ma0 = a1;
            mb0 = b1;
            ma1 = a0;
            mb1 = b0;
        end
        else
        begin
            ma0 = a0;
            mb0 = b0;
            ma1 = a1;
            mb1 = b1;
        end

        dminor = (mb0 > mb1) ? (mb0 - mb1) : (mb1 - mb0);

        if (brush == '0)
            side = SIDE_W'(1);
        else if (SIDE_CMP_W'(brush) > SIDE_CMP_W'(BRUSH_MAX))
            side = SIDE_W'(BRUSH_MAX);
        else
            side = brush;

        setup.steep       = steep;
        setup.major_pos   = ma0;
        setup.minor_pos   = mb0;
        setup.major_end   = ma1;
        setup.delta_major = ma1 - ma0;
        setup.delta_minor = dminor;
        setup.decision    = {1'b0, dminor, 1'b0} - {2'b00, ma1 - ma0};
        setup.minor_down  = mb1 < mb0;
        setup.brush_side  = side;
        setup.red         = red;
        setup.green       = green;
        setup.blue        = blue;
    end

endmodule

// ----- hw/rtl/blbr_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blbr_walker
// line state, brush walk and one bresenham step per finished stamp
// ----------------------------------------------------------------------------
module blbr_walker
    import blbr_pkg::*;
#(
    parameter int RASTER_SIZE = 1024,
    parameter int BRUSH_MAX   = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load_fire,
    input  logic        adv_fire,
    input  line_setup_t setup,
    output pixel_t      pixel
);

    localparam int BW = (BRUSH_MAX > 1) ? $clog2(BRUSH_MAX) : 1;
    localparam int CW = ($clog2(RASTER_SIZE + 1) > COORD_W + 1) ?
                        $clog2(RASTER_SIZE + 1) : COORD_W + 1;

    logic                         active_reg;
    logic                         active_next;
    logic                         steep_reg;
    coord_t                       major_pos_reg;
    coord_t                       major_pos_next;
    coord_t                       minor_pos_reg;
    coord_t                       minor_pos_next;
    coord_t                       major_end_reg;
    coord_t                       delta_major_reg;
    coord_t                       delta_minor_reg;
    logic signed [DECISION_W-1:0] decision_reg;
    logic signed [DECISION_W-1:0] decision_next;
    logic                         minor_down_reg;
    logic [BW-1:0]                row_reg;
    logic [BW-1:0]                row_next;
    logic [BW-1:0]                col_reg;
    logic [BW-1:0]                col_next;
    logic [SIDE_W-1:0]            side_reg;
    colour_t                      red_reg;
    colour_t                      green_reg;
    colour_t                      blue_reg;

    coord_t                       cx;
    coord_t                       cy;
    logic [COORD_W:0]             px;
    logic [COORD_W:0]             py;
    logic                         col_wrap;
    logic                         row_wrap;
    logic                         last;
    logic                         in_raster;

    always_comb
    begin
        cx        = steep_reg ? minor_pos_reg : major_pos_reg;
        cy        = steep_reg ? major_pos_reg : minor_pos_reg;
        px        = (COORD_W + 1)'(cx) + (COORD_W + 1)'(row_reg);
        py        = (COORD_W + 1)'(cy) + (COORD_W + 1)'(col_reg);
        col_wrap  = (SIDE_CMP_W'(col_reg) + SIDE_CMP_W'(1)) >= SIDE_CMP_W'(side_reg);
        row_wrap  = (SIDE_CMP_W'(row_reg) + SIDE_CMP_W'(1)) >= SIDE_CMP_W'(side_reg);
        last      = (major_pos_reg == major_end_reg) && row_wrap && col_wrap;
        in_raster = (CW'(px) < CW'(RASTER_SIZE)) && (CW'(py) < CW'(RASTER_SIZE));

        active_next    = active_reg;
        major_pos_next = major_pos_reg;
        minor_pos_next = minor_pos_reg;
        decision_next  = decision_reg;
        row_next       = row_reg;
        col_next       = col_reg;

        if (col_wrap)
        begin
            col_next = '0;
            if (row_wrap)
            begin
                row_next = '0;
                if (last)
                    active_next = 1'b0;
                else
                begin
                    major_pos_next = major_pos_reg + COORD_W'(1);
                    if (decision_reg > 0)
                    begin
                        minor_pos_next = minor_down_reg ? (minor_pos_reg - COORD_W'(1)) :
                                                          (minor_pos_reg + COORD_W'(1));
                        decision_next  = decision_reg
                                       + ({1'b0, delta_minor_reg, 1'b0}
                                       -  {1'b0, delta_major_reg, 1'b0});
                    end
                    else
                        decision_next = decision_reg + {1'b0, delta_minor_reg, 1'b0};
                end
            end
            else
                row_next = row_reg + BW'(1);
        end
        else
            col_next = col_reg + BW'(1);

        pixel.valid = active_reg && in_raster;
        pixel.x     = px[COORD_W-1:0];
        pixel.y     = py[COORD_W-1:0];
        pixel.red   = red_reg;
        pixel.green = green_reg;
        pixel.blue  = blue_reg;
        pixel.last  = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg      <= 1'b0;
            steep_reg       <= 1'b0;
            major_pos_reg   <= '0;
            minor_pos_reg   <= '0;
            major_end_reg   <= '0;
            delta_major_reg <= '0;
            delta_minor_reg <= '0;
            decision_reg    <= '0;
            minor_down_reg  <= 1'b0;
            row_reg         <= '0;
            col_reg         <= '0;
            side_reg        <= SIDE_W'(1);
            red_reg         <= '0;
            green_reg       <= '0;
            blue_reg        <= '0;
        end
        else if (load_fire)
        begin
            active_reg      <= 1'b1;
            steep_reg       <= setup.steep;
            major_pos_reg   <= setup.major_pos;
            minor_pos_reg   <= setup.minor_pos;
            major_end_reg   <= setup.major_end;
            delta_major_reg <= setup.delta_major;
            delta_minor_reg <= setup.delta_minor;
            decision_reg    <= setup.decision;
            minor_down_reg  <= setup.minor_down;
            row_reg         <= '0;
            col_reg         <= '0;
            side_reg        <= setup.brush_side;
            red_reg         <= setup.red;
            green_reg       <= setup.green;
            blue_reg        <= setup.blue;
        end
        else if (adv_fire && active_reg)
        begin
            active_reg    <= active_next;
            major_pos_reg <= major_pos_next;
            minor_pos_reg <= minor_pos_next;
            decision_reg  <= decision_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
        end
    end

endmodule

// ----- hw/rtl/bresenham_line_brush_raster_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bresenham_line_brush_raster_core
// bresenham line rasteriser with a square brush, at most one pixel write per advance
// ----------------------------------------------------------------------------
// A load request (cmd 0) latches both endpoints, the colour and the brush
// side and produces no pixel. Each advance request (cmd 1) produces at most
// one pixel write: the brush square is walked row by row and one Bresenham
// step follows each finished stamp; the final write of the line carries
// last_pixel. Writes that land outside the raster are dropped. The core takes
// one request every clock cycle unless in_stall holds it while the output
// stalls; a request passes from the input register through the single pass
// of the line state into the result register.
// ----------------------------------------------------------------------------
module bresenham_line_brush_raster_core
    import blbr_pkg::*;
#(
    parameter int RASTER_SIZE = 1024,
    parameter int BRUSH_MAX   = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic              cmd,
    input  coord_t            x_start,
    input  coord_t            y_start,
    input  coord_t            x_end,
    input  coord_t            y_end,
    input  colour_t           red,
    input  colour_t           green,
    input  colour_t           blue,
    input  logic [SIDE_W-1:0] brush,
    output logic              out_valid,
    input  logic              out_stall,
    output coord_t            pix_x,
    output coord_t            pix_y,
    output colour_t           out_red,
    output colour_t           out_green,
    output colour_t           out_blue,
    output logic              last_pixel
);

    logic              req_valid_reg;
    logic              req_valid_next;
    logic              req_cmd_reg;
    coord_t            req_x_start_reg;
    coord_t            req_y_start_reg;
    coord_t            req_x_end_reg;
    coord_t            req_y_end_reg;
    colour_t           req_red_reg;
    colour_t           req_green_reg;
    colour_t           req_blue_reg;
    logic [SIDE_W-1:0] req_brush_reg;

    logic              out_valid_reg;
    logic              out_valid_next;
    pixel_t            out_pix_reg;

    logic              pass_ok;
    logic              req_fire;
    logic              in_fire;
    line_setup_t       setup;
    pixel_t            pixel;

    // the pass moves on whenever the result register is free or being emptied
    assign pass_ok  = !out_valid_reg || !out_stall;
    assign req_fire = req_valid_reg && pass_ok;
    assign in_stall = req_valid_reg && !pass_ok;
    assign in_fire  = in_valid && !in_stall;

    blbr_setup #(
        .BRUSH_MAX (BRUSH_MAX)
    ) u_setup (
        .x_start (req_x_start_reg),
        .y_start (req_y_start_reg),
        .x_end   (req_x_end_reg),
        .y_end   (req_y_end_reg),
        .red     (req_red_reg),
        .green   (req_green_reg),
        .blue    (req_blue_reg),
        .brush   (req_brush_reg),
        .setup   (setup)
    );

    blbr_walker #(
        .RASTER_SIZE (RASTER_SIZE),
        .BRUSH_MAX   (BRUSH_MAX)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .load_fire (req_fire && (req_cmd_reg == CMD_LOAD)),
        .adv_fire  (req_fire && (req_cmd_reg == CMD_ADVANCE)),
        .setup     (setup),
        .pixel     (pixel)
    );

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (in_fire)
            req_valid_next = 1'b1;
        else if (req_fire)
            req_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (pass_ok)
            out_valid_next = req_fire && (req_cmd_reg == CMD_ADVANCE) && pixel.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_cmd_reg     <= cmd;
            req_x_start_reg <= x_start;
            req_y_start_reg <= y_start;
            req_x_end_reg   <= x_end;
            req_y_end_reg   <= y_end;
            req_red_reg     <= red;
            req_green_reg   <= green;
            req_blue_reg    <= blue;
            req_brush_reg   <= brush;
        end
        if (pass_ok)
            out_pix_reg <= pixel;
    end

    assign out_valid  = out_valid_reg;
    assign pix_x      = out_pix_reg.x;
    assign pix_y      = out_pix_reg.y;
    assign out_red    = out_pix_reg.red;
    assign out_green  = out_pix_reg.green;
    assign out_blue   = out_pix_reg.blue;
    assign last_pixel = out_pix_reg.last;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bresenham line brush rasteriser core
// ----------------------------------------------------------------------------
// Requests are sent in random bursts while the pixel side stalls on a
// changing pattern of its own. A line tracker inside the bench follows every
// accepted request, keeps its own copy of the line state and queues the pixel
// writes it expects; each write taken from the core is compared field by
// field with the oldest one queued. Directed lines cover the raster corners,
// clipped writes, brush clamping, steep and falling lines and a load that
// cuts a line short; random lines and noise follow, with one full drain in
// the middle.
// ----------------------------------------------------------------------------
module tb_top;
    import blbr_pkg::*;

    localparam int RASTER    = 1024;
    localparam int BRUSH_TOP = 8;
    localparam int LIMIT     = 400000;
    localparam int ITEMS     = 1050;

    typedef struct {
        coord_t  x;
        coord_t  y;
        colour_t red;
        colour_t green;
        colour_t blue;
        logic    is_last;
    } pixel_write_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic              in_stall;
    logic              cmd        = CMD_LOAD;
    coord_t            x_start    = '0;
    coord_t            y_start    = '0;
    coord_t            x_end      = '0;
    coord_t            y_end      = '0;
    colour_t           red        = '0;
    colour_t           green      = '0;
    colour_t           blue       = '0;
    logic [SIDE_W-1:0] brush      = 4'd1;
    logic              out_valid;
    logic              out_stall  = 1'b0;
    coord_t            pix_x;
    coord_t            pix_y;
    colour_t           out_red;
    colour_t           out_green;
    colour_t           out_blue;
    logic              last_pixel;

    // line tracker state
    bit      line_on     = 1'b0;
    bit      steep       = 1'b0;
    int      major_pos   = 0;
    int      minor_pos   = 0;
    int      major_end   = 0;
    int      d_major     = 0;
    int      d_minor     = 0;
    int      decision    = 0;
    bit      minor_down  = 1'b0;
    int      brush_row   = 0;
    int      brush_col   = 0;
    int      brush_side  = 1;
    colour_t line_red    = '0;
    colour_t line_green  = '0;
    colour_t line_blue   = '0;

    pixel_write_t pending_pixels[$];
    pixel_write_t expected_pix;
    int           fail_count   = 0;
    int           useful_count = 0;
    int           burst_left   = 0;
    int           cycle_count  = 0;
    stall_mode_t  stall_mode   = STALL_NONE;
    int           stall_left   = 0;
    int           stall_tick   = 0;

    bresenham_line_brush_raster_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .x_start    (x_start),
        .y_start    (y_start),
        .x_end      (x_end),
        .y_end      (y_end),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .brush      (brush),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pix_x      (pix_x),
        .pix_y      (pix_y),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .last_pixel (last_pixel)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // pixel side stall pattern
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= stall_mode_t'($urandom_range(0, 3));
            stall_left <= $urandom_range(30, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            STALL_NONE:  out_stall <= 1'b0;
            STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
            default:     out_stall <= (stall_tick % 3 == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("pixel write with none expected: x %0d y %0d", pix_x, pix_y);
                fail_count++;
            end
            else
            begin
                expected_pix = pending_pixels.pop_front();
                if (pix_x !== expected_pix.x)
                begin
                    $error("pix_x: expected %0d, actual %0d", expected_pix.x, pix_x);
                    fail_count++;
                end
                if (pix_y !== expected_pix.y)
                begin
                    $error("pix_y: expected %0d, actual %0d", expected_pix.y, pix_y);
                    fail_count++;
                end
                if (out_red !== expected_pix.red)
                begin
                    $error("out_red: expected %0d, actual %0d", expected_pix.red, out_red);
                    fail_count++;
                end
                if (out_green !== expected_pix.green)
                begin
                    $error("out_green: expected %0d, actual %0d", expected_pix.green,
                           out_green);
                    fail_count++;
                end
                if (out_blue !== expected_pix.blue)
                begin
                    $error("out_blue: expected %0d, actual %0d", expected_pix.blue, out_blue);
                    fail_count++;
                end
                if (last_pixel !== expected_pix.is_last)
                begin
                    $error("last_pixel: expected %0d, actual %0d", expected_pix.is_last,
                           last_pixel);
                    fail_count++;
                end
            end
        end
    end

    function automatic int span(input int p, input int q);
        return (p > q) ? p - q : q - p;
    endfunction

    // follows one accepted request and queues the pixel write it should give
    task automatic raster_predict(input logic c, input coord_t xs, input coord_t ys,
                                  input coord_t xe, input coord_t ye,
                                  input colour_t r, input colour_t g, input colour_t b,
                                  input logic [SIDE_W-1:0] br);
        int           a0;
        int           b0;
        int           a1;
        int           b1;
        int           t;
        int           cx;
        int           cy;
        int           px;
        int           py;
        bit           is_last;
        pixel_write_t pix;
        if (c == CMD_LOAD)
        begin
            steep = span(int'(ys), int'(ye)) > span(int'(xs), int'(xe));
            if (steep)
            begin
                a0 = int'(ys); b0 = int'(xs); a1 = int'(ye); b1 = int'(xe);
            end
            else
            begin
                a0 = int'(xs); b0 = int'(ys); a1 = int'(xe); b1 = int'(ye);
            end
            if (a0 > a1)
            begin
                t = a0; a0 = a1; a1 = t;
                t = b0; b0 = b1; b1 = t;
            end
            d_major    = a1 - a0;
            d_minor    = span(b0, b1);
            minor_down = b1 < b0;
            decision   = 2 * d_minor - d_major;
            major_pos  = a0;
            minor_pos  = b0;
            major_end  = a1;
            brush_side = (br == 0) ? 1 : ((br > BRUSH_TOP) ? BRUSH_TOP : int'(br));
            brush_row  = 0;
            brush_col  = 0;
            line_red   = r;
            line_green = g;
            line_blue  = b;
            line_on    = 1'b1;
            useful_count++;
        end
        else if (line_on)
        begin
            useful_count++;
            cx = steep ? minor_pos : major_pos;
            cy = steep ? major_pos : minor_pos;
            px = cx + brush_row;
            py = cy + brush_col;
            is_last = (major_pos == major_end) && (brush_row + 1 >= brush_side) &&
                      (brush_col + 1 >= brush_side);
            brush_col++;
            if (brush_col >= brush_side)
            begin
                brush_col = 0;
                brush_row++;
                if (brush_row >= brush_side)
                begin
                    brush_row = 0;
                    if (is_last)
                    begin
                        line_on = 1'b0;
                    end
                    else
                    begin
                        major_pos = (major_pos + 1) & 'h3FF;
                        if (decision > 0)
                        begin
                            minor_pos = minor_down ? ((minor_pos - 1) & 'h3FF)
                                                   : ((minor_pos + 1) & 'h3FF);
                            decision += 2 * (d_minor - d_major);
                        end
                        else
                        begin
                            decision += 2 * d_minor;
                        end
                    end
                end
            end
            if (px < RASTER && py < RASTER)
            begin
                pix.x       = px[COORD_W-1:0];
                pix.y       = py[COORD_W-1:0];
                pix.red     = line_red;
                pix.green   = line_green;
                pix.blue    = line_blue;
                pix.is_last = is_last;
                pending_pixels.push_back(pix);
            end
        end
    endtask

    // one request, held until taken, then a burst or a gap
    task automatic send_request(input logic c, input coord_t xs, input coord_t ys,
                                input coord_t xe, input coord_t ye,
                                input colour_t r, input colour_t g, input colour_t b,
                                input logic [SIDE_W-1:0] br);
        int gap;
        in_valid <= 1'b1;
        cmd      <= c;
        x_start  <= xs;
        y_start  <= ys;
        x_end    <= xe;
        y_end    <= ye;
        red      <= r;
        green    <= g;
        blue     <= b;
        brush    <= br;
        do
            @(posedge clk);
        while (in_stall);
        raster_predict(c, xs, ys, xe, ye, r, g, b, br);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            burst_left = $urandom_range(0, 24);
            if ($urandom_range(0, 3) != 0)
            begin
                gap = $urandom_range(1, 5);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_advance();
        send_request(CMD_ADVANCE, coord_t'($urandom_range(0, 1023)),
                     coord_t'($urandom_range(0, 1023)),
                     coord_t'($urandom_range(0, 1023)), coord_t'($urandom_range(0, 1023)),
                     colour_t'($urandom_range(0, 255)), colour_t'($urandom_range(0, 255)),
                     colour_t'($urandom_range(0, 255)), 4'($urandom_range(0, 15)));
    endtask

    task automatic draw_line(input coord_t xs, input coord_t ys, input coord_t xe,
                             input coord_t ye, input colour_t r, input colour_t g,
                             input colour_t b, input logic [SIDE_W-1:0] br);
        send_request(CMD_LOAD, xs, ys, xe, ye, r, g, b, br);
        while (line_on)
            send_advance();
    endtask

    task automatic wait_for_pixels();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic test_idle_advance();
        send_advance();
        send_advance();
    endtask

    // corner point, most of the brush falls off the raster and so does the last write
    task automatic test_clipped_point();
        draw_line(10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255, 8'd255, 8'd255, 4'd2);
    endtask

    task automatic test_brush_clamp();
        send_request(CMD_LOAD, 10'd0, 10'd0, 10'd1, 10'd0, 8'd17, 8'd34, 8'd51, 4'd15);
        repeat (3) send_advance();
        draw_line(10'd0, 10'd0, 10'd3, 10'd0, 8'd0, 8'd0, 8'd0, 4'd0);
    endtask

    task automatic test_steep_falling();
        draw_line(10'd0, 10'd3, 10'd1, 10'd0, 8'd200, 8'd1, 8'd128, 4'd1);
    endtask

    task automatic test_shallow_reversed();
        draw_line(10'd3, 10'd0, 10'd0, 10'd1, 8'd85, 8'd170, 8'd255, 4'd1);
    endtask

    function automatic coord_t pick_coord();
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return coord_t'($urandom_range(1008, 1023));
        else if (sel == 1)
            return coord_t'($urandom_range(0, 15));
        return coord_t'($urandom_range(0, 1023));
    endfunction

    function automatic coord_t near_coord(input coord_t base, input int reach);
        int v;
        v = int'(base) + $urandom_range(0, 2 * reach) - reach;
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return coord_t'(v);
    endfunction

    task automatic test_random_lines(input int target);
        int                kind;
        int                sel;
        int                reach;
        int                steps;
        coord_t            xs;
        coord_t            ys;
        logic [SIDE_W-1:0] br;
        while (useful_count < target)
        begin
            kind = $urandom_range(0, 19);
            sel  = $urandom_range(0, 19);
            if (sel < 10)
                br = 4'd1;
            else if (sel < 15)
                br = 4'($urandom_range(2, 3));
            else if (sel < 18)
                br = 4'($urandom_range(4, 8));
            else
                br = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(9, 15));
            reach = (br >= 4) ? 2 : 14;
            xs = pick_coord();
            ys = pick_coord();
            if (kind == 0)
            begin
                // noise: random commands with unbounded endpoints
                steps = $urandom_range(1, 4);
                repeat (steps)
                    send_request(1'($urandom_range(0, 1)), coord_t'($urandom_range(0, 1023)),
                                 coord_t'($urandom_range(0, 1023)),
                                 coord_t'($urandom_range(0, 1023)),
                                 coord_t'($urandom_range(0, 1023)),
                                 colour_t'($urandom_range(0, 255)),
                                 colour_t'($urandom_range(0, 255)),
                                 colour_t'($urandom_range(0, 255)),
                                 4'($urandom_range(0, 15)));
            end
            else if (kind == 1)
            begin
                // line cut short by the next load
                send_request(CMD_LOAD, xs, ys, near_coord(xs, reach), near_coord(ys, reach),
                             colour_t'($urandom_range(0, 255)),
                             colour_t'($urandom_range(0, 255)),
                             colour_t'($urandom_range(0, 255)), br);
                steps = $urandom_range(0, 6);
                repeat (steps) send_advance();
            end
            else
            begin
                draw_line(xs, ys, near_coord(xs, reach), near_coord(ys, reach),
                          colour_t'($urandom_range(0, 255)), colour_t'($urandom_range(0, 255)),
                          colour_t'($urandom_range(0, 255)), br);
                if ($urandom_range(0, 3) == 0)
                    send_advance();
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_advance();
        test_clipped_point();
        test_brush_clamp();
        test_steep_falling();
        test_shallow_reversed();
        test_random_lines(ITEMS / 2);
        wait_for_pixels();
        test_random_lines(ITEMS);
        wait_for_pixels();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_pixels.size() == 0)
        begin
            $display("tb_top: PASS");
        end
        else
        begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
